// ===== rtl/rabs_pkg.sv =====
// Shared constants, types and helper functions for the background subtractor.
package rabs_pkg;

  localparam int unsigned PIXELS_DEF  = 131072;
  localparam int unsigned ADDR_IN_W   = 17;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned OUT_DEPTH   = 8;
  localparam int unsigned APB_AW      = 5;
  localparam int unsigned APB_DW      = 32;

  localparam int unsigned LUMA_R     = 4899;
  localparam int unsigned LUMA_G     = 9617;
  localparam int unsigned LUMA_B     = 1868;
  localparam int unsigned LUMA_ROUND = 8192;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_PROC = 1'b1;

  localparam logic [1:0] KIND_IGNORE = 2'd0;
  localparam logic [1:0] KIND_LOAD   = 2'd1;
  localparam logic [1:0] KIND_PROC   = 2'd2;

  localparam logic [1:0] MODE_PLAIN  = 2'd0;
  localparam logic [1:0] MODE_BLEND  = 2'd1;
  localparam logic [1:0] MODE_SELECT = 2'd2;
  localparam logic [1:0] MODE_GHOST  = 2'd3;

  localparam logic COLOR_GRAY = 1'b0;
  localparam logic COLOR_BGR  = 1'b1;

  localparam logic [2:0] REG_THRESH = 3'd0;
  localparam logic [2:0] REG_WEIGHT = 3'd1;
  localparam logic [2:0] REG_MODE   = 3'd2;
  localparam logic [2:0] REG_COLOR  = 3'd3;
  localparam logic [2:0] REG_GHOST  = 3'd4;

  localparam logic [7:0] THRESH_RST = 8'd30;
  localparam logic [8:0] WEIGHT_RST = 9'd13;
  localparam logic [1:0] MODE_RST   = MODE_PLAIN;
  localparam logic       COLOR_RST  = COLOR_BGR;
  localparam logic [7:0] GHOST_RST  = 8'd50;

  typedef struct packed {
    logic [7:0] fg_threshold;
    logic [8:0] blend_weight;
    logic [1:0] update_mode;
    logic       color_mode;
    logic [7:0] ghost_limit;
  } cfg_t;

  typedef struct packed {
    logic [1:0]      kind;
    logic [2:0][7:0] px;
  } item_t;

  typedef struct packed {
    logic [2:0]      fg_bits;
    logic [2:0][7:0] diff;
  } result_t;

  function automatic logic [8:0] sat_weight(input logic [8:0] w);
    return (w > 9'd256) ? 9'd256 : w;
  endfunction

  function automatic logic [2:0] chan_mask(input logic color);
    return (color == COLOR_GRAY) ? 3'b001 : 3'b111;
  endfunction

endpackage

// ===== rtl/rabs_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module rabs_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/rabs_fifo.sv =====
// Small register-based FIFO with a fill count.
module rabs_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push_valid,
  output logic                       push_ready,
  input  logic [WIDTH-1:0]           push_data,
  output logic                       pop_valid,
  input  logic                       pop_ready,
  output logic [WIDTH-1:0]           pop_data,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int unsigned PW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    fill;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (fill != CW'(DEPTH));
  assign pop_valid  = (fill != '0);
  assign pop_data   = mem[rd_ptr];
  assign count      = fill;
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      fill <= fill + CW'(do_push) - CW'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

endmodule

// ===== rtl/rabs_front.sv =====
// Front end: accept items, range check, classify and, in gray mode, convert to luma.
module rabs_front #(
  parameter int unsigned PIXELS = rabs_pkg::PIXELS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      hold,
  input  rabs_pkg::cfg_t            cfg,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      cmd,
  input  logic [16:0]               pixel_addr,
  input  logic [7:0]                blue_in,
  input  logic [7:0]                green_in,
  input  logic [7:0]                red_in,
  output logic                      q_valid,
  input  logic                      q_ready,
  output logic [$clog2(PIXELS)-1:0] q_addr,
  output rabs_pkg::item_t           q_item
);

  localparam int unsigned AW = $clog2(PIXELS);
  localparam int unsigned EW = (AW > rabs_pkg::ADDR_IN_W) ? AW : rabs_pkg::ADDR_IN_W;

  logic            f1_valid;
  logic [1:0]      f1_kind;
  logic [AW-1:0]   f1_addr;
  logic [2:0][7:0] f1_px;
  logic [20:0]     f1_prod_r;
  logic [21:0]     f1_prod_g;
  logic [18:0]     f1_prod_b;

  logic            accept;
  logic            in_range;
  logic [EW-1:0]   addr_ext;
  logic [21:0]     luma_sum;

  assign in_ready = !hold && (!f1_valid || q_ready);
  assign accept   = in_valid && in_ready;
  assign in_range = (32'(pixel_addr) < 32'(PIXELS));
  assign addr_ext = EW'(pixel_addr);

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_valid <= 1'b0;
    end else if (accept) begin
      f1_valid <= 1'b1;
    end else if (q_ready) begin
      f1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      if (!in_range) begin
        f1_kind <= rabs_pkg::KIND_IGNORE;
      end else if (cmd == rabs_pkg::CMD_LOAD) begin
        f1_kind <= rabs_pkg::KIND_LOAD;
      end else begin
        f1_kind <= rabs_pkg::KIND_PROC;
      end
      f1_addr   <= addr_ext[AW-1:0];
      f1_px     <= {red_in, green_in, blue_in};
      f1_prod_r <= 21'(red_in) * 21'(rabs_pkg::LUMA_R);
      f1_prod_g <= 22'(green_in) * 22'(rabs_pkg::LUMA_G);
      f1_prod_b <= 19'(blue_in) * 19'(rabs_pkg::LUMA_B);
    end
  end

  assign luma_sum = 22'(f1_prod_r) + f1_prod_g + 22'(f1_prod_b)
                  + 22'(rabs_pkg::LUMA_ROUND);

  always_comb begin
    q_valid        = f1_valid;
    q_addr         = f1_addr;
    q_item.kind    = f1_kind;
    q_item.px      = f1_px;
    if (cfg.color_mode == rabs_pkg::COLOR_GRAY) begin
      q_item.px[0] = luma_sum[21:14];
    end
  end

endmodule

// ===== rtl/rabs_back.sv =====
// Back end: pipelined read-modify-write of background and ghost stores.
module rabs_back #(
  parameter int unsigned PIXELS = rabs_pkg::PIXELS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  rabs_pkg::cfg_t            cfg,
  input  logic                      q_valid,
  output logic                      q_ready,
  input  logic [$clog2(PIXELS)-1:0] q_addr,
  input  rabs_pkg::item_t           q_item,
  output logic                      out_valid,
  input  logic                      out_ready,
  output rabs_pkg::result_t         out_result,
  output logic                      clearing
);

  localparam int unsigned AW  = $clog2(PIXELS);
  localparam int unsigned OCW = $clog2(rabs_pkg::OUT_DEPTH + 1);

  logic [AW-1:0]         clr_idx;

  logic                  s1_valid;
  rabs_pkg::item_t       s1_item;
  logic [AW-1:0]         s1_addr;

  logic                  s2_valid;
  rabs_pkg::item_t       s2_item;
  logic [AW-1:0]         s2_addr;
  logic [2:0][7:0]       s2_bg;
  logic [2:0][7:0]       s2_cnt;
  logic [2:0][16:0]      s2_prod_p;
  logic [2:0][16:0]      s2_prod_b;

  logic                  s3_valid;
  rabs_pkg::item_t       s3_item;
  logic [AW-1:0]         s3_addr;
  logic [2:0][7:0]       s3_bg;
  logic [2:0][7:0]       s3_cnt;

  logic [2:0][7:0]       bg_rd;
  logic [2:0][7:0]       cnt_rd;
  logic [8:0]            w;
  logic [8:0]            w_inv;
  logic [2:0][16:0]      prod_p;
  logic [2:0][16:0]      prod_b;
  logic [2:0][7:0]       bg_cur;
  logic [2:0]            active;

  logic [2:0]            bg_we;
  logic [2:0][7:0]       bg_wr;
  logic [2:0]            cnt_we;
  logic [2:0][7:0]       cnt_next;
  rabs_pkg::result_t     res;

  logic                  out_push_ready;
  logic [OCW-1:0]        out_fill;
  logic [OCW:0]          inflight;
  logic                  room;
  logic                  hazard;
  logic                  pop;

  assign inflight = (OCW+1)'(out_fill) + (OCW+1)'(s1_valid) + (OCW+1)'(s2_valid)
                  + (OCW+1)'(s3_valid);
  assign room     = (inflight < (OCW+1)'(rabs_pkg::OUT_DEPTH));
  assign hazard   = (q_item.kind != rabs_pkg::KIND_IGNORE) && (
      (s1_valid && s1_item.kind != rabs_pkg::KIND_IGNORE && s1_addr == q_addr) ||
      (s2_valid && s2_item.kind != rabs_pkg::KIND_IGNORE && s2_addr == q_addr) ||
      (s3_valid && s3_item.kind != rabs_pkg::KIND_IGNORE && s3_addr == q_addr));
  assign pop      = q_valid && !clearing && !hazard && room;
  assign q_ready  = pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_idx  <= '0;
    end else if (clearing) begin
      if (clr_idx == AW'(PIXELS - 1)) begin
        clearing <= 1'b0;
      end else begin
        clr_idx <= clr_idx + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else begin
      s1_valid <= pop;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
    end
  end

  assign w      = rabs_pkg::sat_weight(cfg.blend_weight);
  assign w_inv  = 9'd256 - w;
  assign active = rabs_pkg::chan_mask(cfg.color_mode);

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      prod_p[c] = 17'(w) * 17'(s1_item.px[c]);
      prod_b[c] = 17'(w_inv) * 17'(bg_rd[c]);
    end
  end

  always_ff @(posedge clk) begin
    s1_item   <= q_item;
    s1_addr   <= q_addr;
    s2_item   <= s1_item;
    s2_addr   <= s1_addr;
    s2_bg     <= bg_rd;
    s2_cnt    <= cnt_rd;
    s2_prod_p <= prod_p;
    s2_prod_b <= prod_b;
    s3_item   <= s2_item;
    s3_addr   <= s2_addr;
    s3_bg     <= bg_cur;
    s3_cnt    <= s2_cnt;
  end

  always_comb begin
    logic [16:0] sum;
    for (int c = 0; c < 3; c++) begin
      sum = s2_prod_p[c] + s2_prod_b[c] + 17'd128;
      bg_cur[c] = (cfg.update_mode == rabs_pkg::MODE_PLAIN) ? s2_bg[c] : sum[15:8];
    end
  end

  always_comb begin
    logic [7:0] px;
    logic [7:0] bg;
    logic [7:0] diff;
    logic       is_fg;
    logic       is_proc;
    is_proc     = s3_valid && (s3_item.kind == rabs_pkg::KIND_PROC);
    res.fg_bits = '0;
    res.diff    = '0;
    for (int c = 0; c < 3; c++) begin
      px          = s3_item.px[c];
      bg          = s3_bg[c];
      diff        = (px > bg) ? px - bg : bg - px;
      is_fg       = active[c] && (diff > cfg.fg_threshold);
      cnt_next[c] = '0;
      bg_wr[c]    = bg;
      if (is_fg) begin
        cnt_next[c] = (s3_cnt[c] == 8'd255) ? 8'd255 : s3_cnt[c] + 8'd1;
      end
      case (cfg.update_mode)
        rabs_pkg::MODE_SELECT: begin
          if (!is_fg) begin
            bg_wr[c] = px;
          end
        end
        rabs_pkg::MODE_GHOST: begin
          if (is_fg && cnt_next[c] >= cfg.ghost_limit) begin
            bg_wr[c] = px;
          end
        end
        default: begin
        end
      endcase
      if (s3_item.kind == rabs_pkg::KIND_LOAD) begin
        bg_wr[c] = px;
      end
      bg_we[c]  = s3_valid && active[c] && ((s3_item.kind == rabs_pkg::KIND_LOAD) ||
                  (is_proc && cfg.update_mode != rabs_pkg::MODE_PLAIN));
      cnt_we[c] = is_proc && active[c] && (cfg.update_mode == rabs_pkg::MODE_GHOST);
      if (is_proc && active[c]) begin
        res.fg_bits[c] = is_fg;
        res.diff[c]    = diff;
      end
    end
  end

  for (genvar c = 0; c < 3; c++) begin : g_chan
    rabs_ram #(
      .WIDTH (8),
      .DEPTH (PIXELS)
    ) u_bg_ram (
      .clk   (clk),
      .we    (bg_we[c]),
      .waddr (s3_addr),
      .wdata (bg_wr[c]),
      .re    (pop),
      .raddr (q_addr),
      .rdata (bg_rd[c])
    );

    rabs_ram #(
      .WIDTH (8),
      .DEPTH (PIXELS)
    ) u_cnt_ram (
      .clk   (clk),
      .we    (clearing || cnt_we[c]),
      .waddr (clearing ? clr_idx : s3_addr),
      .wdata (clearing ? 8'd0 : cnt_next[c]),
      .re    (pop),
      .raddr (q_addr),
      .rdata (cnt_rd[c])
    );
  end

  rabs_fifo #(
    .WIDTH ($bits(rabs_pkg::result_t)),
    .DEPTH (rabs_pkg::OUT_DEPTH)
  ) u_out_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_valid (s3_valid),
    .push_ready (out_push_ready),
    .push_data  (res),
    .pop_valid  (out_valid),
    .pop_ready  (out_ready),
    .pop_data   (out_result),
    .count      (out_fill)
  );

  a_out_room: assert property (@(posedge clk) disable iff (rst)
    s3_valid |-> out_push_ready)
    else $error("result pushed into a full output buffer");

  a_credit: assert property (@(posedge clk) disable iff (rst)
    inflight <= (OCW+1)'(rabs_pkg::OUT_DEPTH))
    else $error("items in flight exceed output buffer space");

  a_clear_idle: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !(s1_valid || s2_valid || s3_valid))
    else $error("item in back pipeline during store clearing");

endmodule

// ===== rtl/running_average_background_subtractor.sv =====
// Top level: configuration registers, front end, item queue and back end.
//
// The block takes one addressed pixel per clock unless stalled, and returns one result
// item per input item, in order. Each pixel does a read-modify-write of the background
// and ghost counter stores through a three-stage back pipeline; an in-range item whose
// address matches an in-range item still in the back pipeline waits until that item has
// written back. Distinct addresses stream at one item per clock while the output buffer
// has room. An eight-entry output buffer keeps the pipeline moving while the output
// side stalls. After reset the ghost counter store is cleared one entry per clock, all
// PIXELS entries (131072 by default), and in_ready stays low until that pass is done;
// register writes are taken throughout.
module running_average_background_subtractor #(
  parameter int unsigned PIXELS = rabs_pkg::PIXELS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [rabs_pkg::APB_AW-1:0] paddr,
  input  logic [rabs_pkg::APB_DW-1:0] pwdata,
  output logic [rabs_pkg::APB_DW-1:0] prdata,
  output logic                        pready,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        cmd,
  input  logic [16:0]                 pixel_addr,
  input  logic [7:0]                  blue_in,
  input  logic [7:0]                  green_in,
  input  logic [7:0]                  red_in,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [2:0]                  fg_bits,
  output logic [7:0]                  diff_c0,
  output logic [7:0]                  diff_c1,
  output logic [7:0]                  diff_c2
);

  localparam int unsigned AW = $clog2(PIXELS);
  localparam int unsigned QW = AW + $bits(rabs_pkg::item_t);

  rabs_pkg::cfg_t    cfg;
  logic              cfg_wr;
  logic [2:0]        reg_idx;

  logic              clearing;
  logic              fq_valid;
  logic              fq_ready;
  logic [AW-1:0]     fq_addr;
  rabs_pkg::item_t   fq_item;
  logic              bq_valid;
  logic              bq_ready;
  logic [QW-1:0]     bq_data;
  logic [$clog2(rabs_pkg::QUEUE_DEPTH+1)-1:0] q_count;
  rabs_pkg::result_t out_result;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_idx = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.fg_threshold <= rabs_pkg::THRESH_RST;
      cfg.blend_weight <= rabs_pkg::WEIGHT_RST;
      cfg.update_mode  <= rabs_pkg::MODE_RST;
      cfg.color_mode   <= rabs_pkg::COLOR_RST;
      cfg.ghost_limit  <= rabs_pkg::GHOST_RST;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        rabs_pkg::REG_THRESH: cfg.fg_threshold <= pwdata[7:0];
        rabs_pkg::REG_WEIGHT: cfg.blend_weight <= pwdata[8:0];
        rabs_pkg::REG_MODE:   cfg.update_mode  <= pwdata[1:0];
        rabs_pkg::REG_COLOR:  cfg.color_mode   <= pwdata[0];
        rabs_pkg::REG_GHOST:  cfg.ghost_limit  <= pwdata[7:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      rabs_pkg::REG_THRESH: prdata = 32'(cfg.fg_threshold);
      rabs_pkg::REG_WEIGHT: prdata = 32'(cfg.blend_weight);
      rabs_pkg::REG_MODE:   prdata = 32'(cfg.update_mode);
      rabs_pkg::REG_COLOR:  prdata = 32'(cfg.color_mode);
      rabs_pkg::REG_GHOST:  prdata = 32'(cfg.ghost_limit);
      default:              prdata = '0;
    endcase
  end

  rabs_front #(
    .PIXELS (PIXELS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .hold       (clearing),
    .cfg        (cfg),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .cmd        (cmd),
    .pixel_addr (pixel_addr),
    .blue_in    (blue_in),
    .green_in   (green_in),
    .red_in     (red_in),
    .q_valid    (fq_valid),
    .q_ready    (fq_ready),
    .q_addr     (fq_addr),
    .q_item     (fq_item)
  );

  rabs_fifo #(
    .WIDTH (QW),
    .DEPTH (rabs_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (fq_valid),
    .push_ready (fq_ready),
    .push_data  ({fq_addr, fq_item}),
    .pop_valid  (bq_valid),
    .pop_ready  (bq_ready),
    .pop_data   (bq_data),
    .count      (q_count)
  );

  rabs_back #(
    .PIXELS (PIXELS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .q_valid    (bq_valid),
    .q_ready    (bq_ready),
    .q_addr     (bq_data[QW-1:$bits(rabs_pkg::item_t)]),
    .q_item     (bq_data[$bits(rabs_pkg::item_t)-1:0]),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_result (out_result),
    .clearing   (clearing)
  );

  assign fg_bits = out_result.fg_bits;
  assign diff_c0 = out_result.diff[0];
  assign diff_c1 = out_result.diff[1];
  assign diff_c2 = out_result.diff[2];

  a_clear_block: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !in_ready)
    else $error("item accepted during store clearing");

  a_queue_clear: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !bq_ready)
    else $error("queue drained during store clearing");

  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    q_count <= ($clog2(rabs_pkg::QUEUE_DEPTH+1))'(rabs_pkg::QUEUE_DEPTH))
    else $error("queue fill count out of range");

endmodule
